>>> hdl/go_back_n_sender_defines.svh
// assertion macros for the go-back-n sender checker
// expects clk_i and rst_ni in the scope of use
`ifndef GO_BACK_N_SENDER_DEFINES_SVH
`define GO_BACK_N_SENDER_DEFINES_SVH

// checked only outside reset
`define GBN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked in reset as well
`define GBN_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/gbn_pkg.sv
// shared types, constants and codes of the go-back-n sender
// no dependencies
`default_nettype none

package gbn_pkg;

  localparam int SEQ_W             = 16;
  localparam int WINDOW_DEF        = 8;
  localparam int PENDING_DEPTH_DEF = 16;
  localparam int MAX_PAYLOAD       = 255;
  localparam int CFG_DATA_W        = 16;
  localparam int FRAG_W            = 56;

  localparam logic [15:0] TIMEOUT_RST    = 16'd1000;
  localparam logic [3:0]  WINDOW_CFG_RST = 4'd8;

  typedef enum logic [1:0] {
    REQ_FRAG = 2'd0,
    REQ_ACK  = 2'd1,
    REQ_TICK = 2'd2
  } req_type_e;

  typedef enum logic [0:0] {
    CFG_TIMEOUT = 1'b0,
    CFG_WINDOW  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_SEND_RD,
    ST_SEND_EMIT,
    ST_RESEND_RD,
    ST_RESEND_EMIT
  } gbn_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] data_handle;
    logic [15:0] message_size;
    logic [7:0]  fragment_size;
    logic [15:0] ack_sequence;
    logic        ack_valid;
  } gbn_in_t;

  typedef struct packed {
    logic [15:0] sequence_res;
    logic [31:0] out_handle;
    logic [15:0] out_message_size;
    logic [7:0]  out_fragment_size;
    logic        is_resend;
    logic        dropped;
    logic        last;
  } gbn_out_t;

  typedef struct packed {
    logic [31:0] handle;
    logic [15:0] msize;
    logic [7:0]  fsize;
  } frag_t;

  typedef struct packed {
    logic fifo_push;
    logic ack_apply;
    logic tick_dec;
    logic tick_expire;
    logic fifo_rd;
    logic send_emit;
    logic ring_rd;
    logic resend_emit;
    logic drop_emit;
  } gbn_cmd_t;

  typedef struct packed {
    logic fifo_full;
    logic ack_ok;
    logic timer_running;
    logic timer_expired;
    logic os_zero;
    logic can_send;
    logic send_last;
    logic resend_last;
    logic out_free;
  } gbn_sts_t;

endpackage

`default_nettype wire

>>> hdl/go_back_n_sender.sv
// a request is taken in the idle state; each result it causes then takes a fifo or
// ring read, then a load into the output register, so a request with n results
// (n at most WINDOW) is busy for those reads and loads, plus output stalls; a fragment
// or applied ack that sends nothing returns to idle from send read, a refused one from drop
// a new request is taken while the last result still waits in the output register
// reset: asynchronous, clears counters, timer and handshake state; memories not cleared
`default_nettype none

module go_back_n_sender #(
  parameter int WINDOW        = gbn_pkg::WINDOW_DEF,
  parameter int PENDING_DEPTH = gbn_pkg::PENDING_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire gbn_pkg::gbn_in_t               in_req_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      gbn_pkg::gbn_out_t              out_res_o,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [0:0]                     cfg_index_i,
  input  wire logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  gbn_pkg::gbn_cmd_t cmd;
  gbn_pkg::gbn_sts_t sts;

  // the user must write the registers only while idle; the block does not enforce this, so the port never stalls
  assign cfg_ready_o = 1'b1;

  gbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_req_i.req_type),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gbn_dp #(
    .WINDOW        (WINDOW),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

>>> hdl/gbn_ram.sv
// generic ram, one write port and one read port with registered read data
// no dependencies
`default_nettype none

module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/gbn_ctrl.sv
// controller state machine of the go-back-n sender
// depends on gbn_pkg
`default_nettype none

module gbn_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        req_type_i,
  output      logic              in_ready_o,
  input  wire gbn_pkg::gbn_sts_t sts_i,
  output      gbn_pkg::gbn_cmd_t cmd_o
);

  gbn_pkg::gbn_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbn_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      gbn_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (req_type_i)
            gbn_pkg::REQ_FRAG: begin
              if (sts_i.fifo_full) begin
                state_d = gbn_pkg::ST_DROP;
              end else begin
                cmd_o.fifo_push = 1'b1;
                state_d         = gbn_pkg::ST_SEND_RD;
              end
            end
            gbn_pkg::REQ_ACK: begin
              // stale or corrupt acks leave everything alone
              if (sts_i.ack_ok) begin
                cmd_o.ack_apply = 1'b1;
                state_d         = gbn_pkg::ST_SEND_RD;
              end
            end
            gbn_pkg::REQ_TICK: begin
              if (sts_i.timer_running) begin
                if (sts_i.timer_expired) begin
                  cmd_o.tick_expire = 1'b1;
                  if (!sts_i.os_zero) begin
                    state_d = gbn_pkg::ST_RESEND_RD;
                  end
                end else begin
                  cmd_o.tick_dec = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      gbn_pkg::ST_DROP: begin
        if (sts_i.out_free) begin
          cmd_o.drop_emit = 1'b1;
          state_d         = gbn_pkg::ST_IDLE;
        end
      end
      gbn_pkg::ST_SEND_RD: begin
        if (sts_i.can_send) begin
          cmd_o.fifo_rd = 1'b1;
          state_d       = gbn_pkg::ST_SEND_EMIT;
        end else begin
          state_d = gbn_pkg::ST_IDLE;
        end
      end
      gbn_pkg::ST_SEND_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.send_emit = 1'b1;
          state_d = sts_i.send_last ? gbn_pkg::ST_IDLE : gbn_pkg::ST_SEND_RD;
        end
      end
      gbn_pkg::ST_RESEND_RD: begin
        cmd_o.ring_rd = 1'b1;
        state_d       = gbn_pkg::ST_RESEND_EMIT;
      end
      gbn_pkg::ST_RESEND_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.resend_emit = 1'b1;
          state_d = sts_i.resend_last ? gbn_pkg::ST_IDLE : gbn_pkg::ST_RESEND_RD;
        end
      end
      default: state_d = gbn_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/gbn_dp.sv
// datapath of the go-back-n sender: window counters, timer, pending fifo,
// retransmit ring and output register; depends on gbn_pkg and gbn_ram
`default_nettype none

module gbn_dp #(
  parameter int WINDOW        = gbn_pkg::WINDOW_DEF,
  parameter int PENDING_DEPTH = gbn_pkg::PENDING_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire gbn_pkg::gbn_in_t                 in_req_i,
  input  wire logic                             cfg_valid_i,
  input  wire logic [0:0]                       cfg_index_i,
  input  wire logic [gbn_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             out_ready_i,
  output      logic                             out_valid_o,
  output      gbn_pkg::gbn_out_t                out_res_o,
  input  wire gbn_pkg::gbn_cmd_t                cmd_i,
  output      gbn_pkg::gbn_sts_t                sts_o
);

  localparam int RW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = $clog2(PENDING_DEPTH + 1);

  logic [15:0]   base_q, base_d;
  logic [15:0]   next_q, next_d;
  logic [RW-1:0] head_q, head_d;
  logic [FW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic [15:0]   timer_q, timer_d;
  logic          running_q, running_d;
  logic [RW:0]   idx_q, idx_d;
  logic [15:0]   timeout_q;
  logic [3:0]    win_cfg_q;
  logic          out_valid_q, out_valid_d;
  gbn_pkg::gbn_out_t out_q, out_d;

  logic [15:0]   os;
  logic [15:0]   win_eff;
  logic [15:0]   timeout_eff;
  logic [15:0]   ack_off;
  logic [15:0]   ack_next;
  logic [FW:0]   wr_sum;
  logic [FW-1:0] wr_addr;
  logic [RW-1:0] ring_waddr;
  logic [RW-1:0] ring_raddr;
  logic [RW-1:0] head_ack;
  logic [7:0]    fsize_sat;
  gbn_pkg::frag_t push_frag;
  gbn_pkg::frag_t fifo_rdata;
  gbn_pkg::frag_t ring_rdata;
  logic          out_free;

  // sum below twice the ring size, one subtract wraps it
  function automatic logic [RW-1:0] ring_wrap(input logic [RW:0] s);
    ring_wrap = (s >= (RW+1)'(WINDOW)) ? RW'(s - (RW+1)'(WINDOW)) : RW'(s);
  endfunction

  assign os          = next_q - base_q;
  assign timeout_eff = (timeout_q == 16'd0) ? 16'd1 : timeout_q;

  always_comb begin
    if (win_cfg_q == 4'd0) begin
      win_eff = 16'd1;
    end else if (16'(win_cfg_q) > 16'(WINDOW)) begin
      win_eff = 16'(WINDOW);
    end else begin
      win_eff = 16'(win_cfg_q);
    end
  end

  assign ack_off  = in_req_i.ack_sequence - base_q;
  assign ack_next = in_req_i.ack_sequence + 16'd1;
  assign head_ack = ring_wrap((RW+1)'(head_q) + (RW+1)'(ack_off[RW-1:0]) + (RW+1)'(1));

  assign wr_sum  = (FW+1)'(rd_ptr_q) + (FW+1)'(count_q);
  assign wr_addr = (wr_sum >= (FW+1)'(PENDING_DEPTH)) ?
                   FW'(wr_sum - (FW+1)'(PENDING_DEPTH)) : FW'(wr_sum);

  assign ring_waddr = ring_wrap((RW+1)'(head_q) + os[RW:0]);
  assign ring_raddr = ring_wrap((RW+1)'(head_q) + idx_q);

  assign fsize_sat = (in_req_i.fragment_size > 8'(gbn_pkg::MAX_PAYLOAD)) ?
                     8'(gbn_pkg::MAX_PAYLOAD) : in_req_i.fragment_size;

  assign push_frag.handle = in_req_i.data_handle;
  assign push_frag.msize  = in_req_i.message_size;
  assign push_frag.fsize  = fsize_sat;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.fifo_full     = (count_q >= CW'(PENDING_DEPTH));
    sts_o.ack_ok        = in_req_i.ack_valid && (ack_off < os);
    sts_o.timer_running = running_q;
    sts_o.timer_expired = (timer_q <= 16'd1);
    sts_o.os_zero       = (os == 16'd0);
    sts_o.can_send      = (count_q != '0) && (os < win_eff);
    sts_o.send_last     = (count_q == CW'(1)) || ((os + 16'd1) >= win_eff);
    sts_o.resend_last   = ((16'(idx_q) + 16'd1) == os);
    sts_o.out_free      = out_free;
  end

  gbn_ram #(
    .WIDTH (gbn_pkg::FRAG_W),
    .DEPTH (PENDING_DEPTH)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fifo_push),
    .waddr_i (wr_addr),
    .wdata_i (push_frag),
    .re_i    (cmd_i.fifo_rd),
    .raddr_i (rd_ptr_q),
    .rdata_o (fifo_rdata)
  );

  gbn_ram #(
    .WIDTH (gbn_pkg::FRAG_W),
    .DEPTH (WINDOW)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.send_emit),
    .waddr_i (ring_waddr),
    .wdata_i (fifo_rdata),
    .re_i    (cmd_i.ring_rd),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  always_comb begin
    base_d      = base_q;
    next_d      = next_q;
    head_d      = head_q;
    rd_ptr_d    = rd_ptr_q;
    count_d     = count_q;
    timer_d     = timer_q;
    running_d   = running_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (cmd_i.fifo_push) begin
      count_d = count_q + CW'(1);
    end

    if (cmd_i.ack_apply) begin
      base_d = ack_next;
      head_d = head_ack;
      if (ack_next == next_q) begin
        running_d = 1'b0;
        timer_d   = 16'd0;
      end else begin
        running_d = 1'b1;
        timer_d   = timeout_eff;
      end
    end

    if (cmd_i.tick_dec) begin
      timer_d = timer_q - 16'd1;
    end

    if (cmd_i.tick_expire) begin
      running_d = 1'b1;
      timer_d   = timeout_eff;
      idx_d     = '0;
    end

    if (cmd_i.send_emit) begin
      rd_ptr_d = (rd_ptr_q == FW'(PENDING_DEPTH - 1)) ? '0 : rd_ptr_q + FW'(1);
      count_d  = count_q - CW'(1);
      next_d   = next_q + 16'd1;
      // first outstanding fragment arms the timer
      if (os == 16'd0) begin
        running_d = 1'b1;
        timer_d   = timeout_eff;
      end
      out_valid_d             = 1'b1;
      out_d.sequence_res      = next_q;
      out_d.out_handle        = fifo_rdata.handle;
      out_d.out_message_size  = fifo_rdata.msize;
      out_d.out_fragment_size = fifo_rdata.fsize;
      out_d.is_resend         = 1'b0;
      out_d.dropped           = 1'b0;
      out_d.last              = sts_o.send_last;
    end

    if (cmd_i.resend_emit) begin
      idx_d                   = idx_q + (RW+1)'(1);
      out_valid_d             = 1'b1;
      out_d.sequence_res      = base_q + 16'(idx_q);
      out_d.out_handle        = ring_rdata.handle;
      out_d.out_message_size  = ring_rdata.msize;
      out_d.out_fragment_size = ring_rdata.fsize;
      out_d.is_resend         = 1'b1;
      out_d.dropped           = 1'b0;
      out_d.last              = sts_o.resend_last;
    end

    if (cmd_i.drop_emit) begin
      out_valid_d   = 1'b1;
      out_d         = '0;
      out_d.dropped = 1'b1;
      out_d.last    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      next_q      <= '0;
      head_q      <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      timer_q     <= '0;
      running_q   <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      timeout_q   <= gbn_pkg::TIMEOUT_RST;
      win_cfg_q   <= gbn_pkg::WINDOW_CFG_RST;
    end else begin
      base_q      <= base_d;
      next_q      <= next_d;
      head_q      <= head_d;
      rd_ptr_q    <= rd_ptr_d;
      count_q     <= count_d;
      timer_q     <= timer_d;
      running_q   <= running_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          gbn_pkg::CFG_TIMEOUT: timeout_q <= cfg_data_i;
          gbn_pkg::CFG_WINDOW:  win_cfg_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

`default_nettype wire

>>> hdl/gbn_checker.sv
// port-level checks for go_back_n_sender, bound to the top level
// depends on gbn_pkg and go_back_n_sender_defines.svh
`default_nettype none
`include "go_back_n_sender_defines.svh"

module gbn_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire gbn_pkg::gbn_out_t out_res_o
);

  // a stalled result holds
  `GBN_ASSERT(a_out_hold,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o),
    "result changed while stalled")

  // a refused fragment carries nothing else
  `GBN_ASSERT(a_drop_clean,
    out_valid_o && out_res_o.dropped |-> out_res_o.last && !out_res_o.is_resend &&
    out_res_o.sequence_res == 16'd0 && out_res_o.out_handle == 32'd0,
    "malformed drop result")

  // no new request while results of the current one are still due
  `GBN_ASSERT(a_busy,
    out_valid_o && out_ready_i && !out_res_o.last |-> !in_ready_o,
    "request taken mid item")

  `GBN_ASSERT_RST(a_rst_out, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (.*);

`default_nettype wire
